// File: sv/tlik_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tlik_pkg;
   localparam int CordicStepsDefault = 16;
   localparam int TableLen = 24;
   localparam int XW = 18;
   localparam int LW = 16;
   localparam int ElbowW = 16;
   localparam int ShoulderW = 18;
   localparam int CfgIdxW = 1;
   localparam logic [CfgIdxW-1:0] RegUpper = 1'b0;
   localparam logic [CfgIdxW-1:0] RegLower = 1'b1;
   localparam logic [LW-1:0] UpperReset = 16'd28160;
   localparam logic [LW-1:0] LowerReset = 16'd46080;
   localparam int DivSteps = 29;
   localparam int SqrtSteps = 29;
   localparam logic signed [35:0] Deg90Q16 = 36'sd5898240;
   localparam int ElbowMax = 46080;
   localparam int ShoulderMin = -92160;
   localparam int ShoulderMax = 46080;

   // atan(2^-i) in 1/65536 degree
   function automatic logic signed [35:0] atan_q16(input int i);
      logic signed [35:0] r;
      case (i)
         0: r = 36'sd2949120;  1: r = 36'sd1740967;  2: r = 36'sd919879;
         3: r = 36'sd466945;   4: r = 36'sd234379;   5: r = 36'sd117304;
         6: r = 36'sd58666;    7: r = 36'sd29335;    8: r = 36'sd14668;
         9: r = 36'sd7334;     10: r = 36'sd3667;    11: r = 36'sd1833;
         12: r = 36'sd917;     13: r = 36'sd458;     14: r = 36'sd229;
         15: r = 36'sd115;     16: r = 36'sd57;      17: r = 36'sd29;
         18: r = 36'sd14;      19: r = 36'sd7;       20: r = 36'sd4;
         21: r = 36'sd2;       22: r = 36'sd1;       default: r = 36'sd0;
      endcase
      return r;
   endfunction

   // sideband that rides along the chain
   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic [LW-1:0]        l1;
      logic [LW-1:0]        l2;
      logic                 flag;
   } side_type;
endpackage
`default_nettype wire

// File: sv/tlik_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tlik_req_if;
   import tlik_pkg::*;
   logic valid;
   logic ready;
   logic signed [XW-1:0] target_x;
   logic signed [XW-1:0] target_y;
   modport source (output valid, target_x, target_y, input ready);
   modport sink (input valid, target_x, target_y, output ready);
endinterface

interface tlik_rsp_if;
   import tlik_pkg::*;
   logic valid;
   logic ready;
   logic [ElbowW-1:0] elbow_degrees;
   logic signed [ShoulderW-1:0] shoulder_degrees;
   logic out_of_reach;
   modport source (output valid, elbow_degrees, shoulder_degrees, out_of_reach,
                   input ready);
   modport sink (input valid, elbow_degrees, shoulder_degrees, out_of_reach,
                 output ready);
endinterface
`default_nettype wire

// File: sv/tlik_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// one restoring quotient bit per cell
module tlik_div_cell import tlik_pkg::*; (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [62:0] rem_in,
   input  wire logic [34:0] den_in,
   input  wire logic [28:0] quo_in,
   input  wire logic [5:0]  shift,
   input  wire side_type    side_in,
   input  wire logic        neg_in,
   input  wire logic        sat_in,
   input  wire logic [28:0] sat_val_in,
   output logic [62:0] rem_out,
   output logic [34:0] den_out,
   output logic [28:0] quo_out,
   output side_type    side_out,
   output logic        neg_out,
   output logic        sat_out,
   output logic [28:0] sat_val_out
);
   logic [62:0] trial;
   logic        take;
   assign trial = {28'd0, den_in} << shift;
   assign take = rem_in >= trial;
   always_ff @(posedge clock) begin
      if (en) begin
         rem_out <= take ? rem_in - trial : rem_in;
         quo_out <= {quo_in[27:0], take};
         den_out <= den_in;
         side_out <= side_in;
         neg_out <= neg_in;
         sat_out <= sat_in;
         sat_val_out <= sat_val_in;
      end
   end
endmodule
`default_nettype wire

// File: sv/tlik_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// one root bit per cell, digit-by-digit
module tlik_sqrt_cell import tlik_pkg::*; (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [5:0]  pos,
   input  wire logic [56:0] v_in,
   input  wire logic [28:0] r_in,
   input  wire logic signed [29:0] c_in,
   input  wire side_type    side_in,
   output logic [56:0] v_out,
   output logic [28:0] r_out,
   output logic signed [29:0] c_out,
   output side_type    side_out
);
   // trial = (4r + 1) << 2pos, r holds the high root bits so far
   logic [58:0] trial;
   logic        take;
   assign trial = 59'({r_in, 2'b01}) << {pos, 1'b0};
   assign take = {2'b00, v_in} >= trial;
   always_ff @(posedge clock) begin
      if (en) begin
         v_out <= take ? v_in - trial[56:0] : v_in;
         r_out <= {r_in[27:0], take};
         c_out <= c_in;
         side_out <= side_in;
      end
   end
endmodule
`default_nettype wire

// File: sv/tlik_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// one vectoring micro-rotation for two independent atan2 lanes
module tlik_cordic_cell import tlik_pkg::*; #(
   parameter int Step = 0
) (
   input  wire logic clock,
   input  wire logic en,
   input  wire logic signed [63:0] ax_in, ay_in, bx_in, by_in,
   input  wire logic signed [35:0] az_in, bz_in,
   input  wire logic signed [35:0] ez_in,
   input  wire logic flag_in,
   output logic signed [63:0] ax_out, ay_out, bx_out, by_out,
   output logic signed [35:0] az_out, bz_out,
   output logic signed [35:0] ez_out,
   output logic flag_out
);
   localparam logic signed [35:0] Ang = atan_q16(Step);
   always_ff @(posedge clock) begin
      if (en) begin
         if (ay_in > 0) begin
            ax_out <= ax_in + (ay_in >>> Step);
            ay_out <= ay_in - (ax_in >>> Step);
            az_out <= az_in + Ang;
         end else begin
            ax_out <= ax_in - (ay_in >>> Step);
            ay_out <= ay_in + (ax_in >>> Step);
            az_out <= az_in - Ang;
         end
         if (by_in > 0) begin
            bx_out <= bx_in + (by_in >>> Step);
            by_out <= by_in - (bx_in >>> Step);
            bz_out <= bz_in + Ang;
         end else begin
            bx_out <= bx_in - (by_in >>> Step);
            by_out <= by_in + (bx_in >>> Step);
            bz_out <= bz_in - Ang;
         end
         ez_out <= ez_in;
         flag_out <= flag_in;
      end
   end
endmodule
`default_nettype wire

// File: sv/two_link_planar_inverse_kinematics_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-link planar arm inverse kinematics. Each req transfer carries a target
// (x, y) in 1/256 mm; each rsp transfer returns elbow and shoulder angles in
// 1/256 degree and an out_of_reach flag when the elbow cosine was clamped
// beyond the exact reach limits. One target is taken every cycle while the
// output is not holding a waiting result; each passes through a chain of
// divider cells, square-root cells and CORDIC cells. The whole chain advances
// together and holds when a finished result is not taken. Link lengths are
// written through csr_; the user must write them only while the block is
// idle, the block itself does not enforce it. A length of zero is treated as one.
module two_link_planar_inverse_kinematics_core import tlik_pkg::*; #(
   parameter int CORDIC_STEPS = CordicStepsDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_write_enable,
   input  wire logic [CfgIdxW-1:0] csr_index,
   input  wire logic [LW-1:0] csr_write_data,
   tlik_req_if.sink   req,
   tlik_rsp_if.source rsp
);
   localparam int NS = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;
   localparam int Depth = 4 + DivSteps + 1 + SqrtSteps + 2 + 2 * NS + 2;

   logic [LW-1:0] upper_ff, lower_ff;
   logic [Depth-1:0] vld_ff, vld_in;
   logic adv;

   // one global enable: chain moves unless the output holds a waiting result
   assign adv = !vld_ff[Depth-1] || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= UpperReset;
         lower_ff <= LowerReset;
         vld_ff <= '0;
      end else begin
         if (csr_write_enable && csr_index == RegUpper) upper_ff <= csr_write_data;
         if (csr_write_enable && csr_index == RegLower) lower_ff <= csr_write_data;
         vld_ff <= vld_in;
      end
   end
   assign vld_in = adv ? {vld_ff[Depth-2:0], req.valid} : vld_ff;

   // stage 0: capture, zero length becomes one
   side_type s0_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff.x <= req.target_x;
         s0_ff.y <= req.target_y;
         s0_ff.l1 <= (upper_ff == '0) ? LW'(1) : upper_ff;
         s0_ff.l2 <= (lower_ff == '0) ? LW'(1) : lower_ff;
         s0_ff.flag <= 1'b0;
      end
   end

   // stage 1: squares
   logic [35:0] xx_ff, yy_ff;
   logic [31:0] l11_ff, l22_ff, l12_ff;
   side_type s1_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         xx_ff <= 36'(s0_ff.x) * 36'(s0_ff.x);
         yy_ff <= 36'(s0_ff.y) * 36'(s0_ff.y);
         l11_ff <= s0_ff.l1 * s0_ff.l1;
         l22_ff <= s0_ff.l2 * s0_ff.l2;
         l12_ff <= s0_ff.l1 * s0_ff.l2;
         s1_ff <= s0_ff;
      end
   end

   // stage 2: numerator and denominator
   logic signed [38:0] num_ff;
   logic [34:0] den_ff;
   side_type s2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff <= $signed({3'd0, xx_ff}) + $signed({3'd0, yy_ff})
                 - $signed({7'd0, l11_ff}) - $signed({7'd0, l22_ff});
         den_ff <= {2'd0, l12_ff, 1'b0};
         s2_ff <= s1_ff;
      end
   end

   // stage 3: clamp test and magnitude
   logic [62:0] mag_ff;
   logic [34:0] den3_ff;
   logic neg3_ff, sat3_ff;
   logic [28:0] satv3_ff;
   side_type s3_ff;
   side_type s3_in;
   logic sat3_in;
   logic signed [39:0] dens, num40;
   assign dens = $signed({5'd0, den_ff});
   assign num40 = 40'(num_ff);
   // exact reach limits clamp without the flag
   always_comb begin
      s3_in = s2_ff;
      sat3_in = 1'b0;
      if (num40 >= dens) begin
         sat3_in = 1'b1;
         s3_in.flag = num40 > dens;
      end else if (num40 <= -dens) begin
         sat3_in = 1'b1;
         s3_in.flag = num40 < -dens;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s3_ff <= s3_in;
         den3_ff <= den_ff;
         neg3_ff <= num_ff < 0;
         mag_ff <= {(num_ff < 0) ? 35'(-num_ff) : 35'(num_ff), 28'd0};
         sat3_ff <= sat3_in;
         satv3_ff <= 29'h1000_0000;
      end
   end

   // divider chain: 29 quotient bits (quotient below 2^28 when not clamped)
   logic [62:0] drem [DivSteps+1];
   logic [34:0] dden [DivSteps+1];
   logic [28:0] dquo [DivSteps+1];
   side_type    dside [DivSteps+1];
   logic        dneg [DivSteps+1];
   logic        dsat [DivSteps+1];
   logic [28:0] dsv [DivSteps+1];
   assign drem[0] = mag_ff;
   assign dden[0] = den3_ff;
   assign dquo[0] = '0;
   assign dside[0] = s3_ff;
   assign dneg[0] = neg3_ff;
   assign dsat[0] = sat3_ff;
   assign dsv[0] = satv3_ff;
   for (genvar g = 0; g < DivSteps; g++) begin : g_div
      tlik_div_cell u_cell (
         .clock, .en(adv), .rem_in(drem[g]), .den_in(dden[g]), .quo_in(dquo[g]),
         .shift(6'(DivSteps - 1 - g)), .side_in(dside[g]), .neg_in(dneg[g]),
         .sat_in(dsat[g]), .sat_val_in(dsv[g]),
         .rem_out(drem[g+1]), .den_out(dden[g+1]), .quo_out(dquo[g+1]),
         .side_out(dside[g+1]), .neg_out(dneg[g+1]), .sat_out(dsat[g+1]),
         .sat_val_out(dsv[g+1])
      );
   end

   // stage: signed c2 and 2^56 - c2^2
   logic signed [29:0] c2_ff;
   logic [56:0] rad_ff;
   side_type s4_ff;
   logic [28:0] cmag;
   assign cmag = dsat[DivSteps] ? dsv[DivSteps] : dquo[DivSteps];
   always_ff @(posedge clock) begin
      if (adv) begin
         c2_ff <= dneg[DivSteps] ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
         rad_ff <= 57'h100_0000_0000_0000 - 57'(cmag) * 57'(cmag);
         s4_ff <= dside[DivSteps];
      end
   end

   // square-root chain
   logic [56:0] sv [SqrtSteps+1];
   logic [28:0] sr [SqrtSteps+1];
   logic signed [29:0] sc [SqrtSteps+1];
   side_type ss [SqrtSteps+1];
   assign sv[0] = rad_ff;
   assign sr[0] = '0;
   assign sc[0] = c2_ff;
   assign ss[0] = s4_ff;
   for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
      tlik_sqrt_cell u_cell (
         .clock, .en(adv), .pos(6'(SqrtSteps - 1 - g)), .v_in(sv[g]), .r_in(sr[g]),
         .c_in(sc[g]), .side_in(ss[g]),
         .v_out(sv[g+1]), .r_out(sr[g+1]), .c_out(sc[g+1]), .side_out(ss[g+1])
      );
   end

   // products for the second atan2
   logic signed [47:0] k2_ff, lc_ff;
   logic signed [29:0] c5_ff;
   logic [28:0] s5_ff;
   side_type s5s_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         k2_ff <= $signed({1'b0, ss[SqrtSteps].l2}) * $signed({1'b0, sr[SqrtSteps]});
         lc_ff <= 48'($signed({1'b0, ss[SqrtSteps].l2})) * 48'(sc[SqrtSteps]);
         c5_ff <= sc[SqrtSteps];
         s5_ff <= sr[SqrtSteps];
         s5s_ff <= ss[SqrtSteps];
      end
   end

   // pre-rotation of three vectors: target, (k1,k2), (c2,s2)
   logic signed [63:0] ax0, ay0, bx0, by0;
   logic signed [35:0] az0, bz0, ez0;
   logic flag0;
   logic signed [63:0] tx, ty, kx, ky, cx, cy;
   assign tx = 64'(s5s_ff.x) <<< 24;
   assign ty = 64'(s5s_ff.y) <<< 24;
   assign kx = (64'($signed({1'b0, s5s_ff.l1})) <<< 28) + 64'(lc_ff);
   assign ky = 64'(k2_ff);
   assign cx = 64'(c5_ff);
   assign cy = 64'($signed({1'b0, s5_ff}));

   function automatic logic [163:0] prerot(input logic signed [63:0] x,
                                           input logic signed [63:0] y);
      logic signed [63:0] rx, ry;
      logic signed [35:0] rz;
      rx = x; ry = y; rz = '0;
      if (x < 0) begin
         if (y >= 0) begin rx = y; ry = -x; rz = Deg90Q16; end
         else begin rx = -y; ry = x; rz = -Deg90Q16; end
      end
      return {rx, ry, rz};
   endfunction

   logic signed [63:0] ex_ff, ey_ff;
   logic zero_t_ff, zero_k_ff, zero_e_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         {ax0, ay0, az0} <= prerot(tx, ty);
         {bx0, by0, bz0} <= prerot(kx, ky);
         {ex_ff, ey_ff, ez0} <= prerot(cx, cy);
         zero_t_ff <= tx == 0 && ty == 0;
         zero_k_ff <= kx == 0 && ky == 0;
         zero_e_ff <= cx == 0 && cy == 0;
         flag0 <= s5s_ff.flag;
      end
   end

   // cordic chain; the first NS cells run target and (k1,k2) in lanes a and b,
   // then the next NS cells run the elbow in lane a
   logic signed [63:0] cax [NS+1], cay [NS+1], cbx [NS+1], cby [NS+1];
   logic signed [35:0] caz [NS+1], cbz [NS+1], cez [NS+1];
   logic cfl [NS+1];
   logic signed [63:0] hex [NS+1], hey [NS+1];
   assign cax[0] = ax0; assign cay[0] = ay0; assign caz[0] = az0;
   assign cbx[0] = bx0; assign cby[0] = by0; assign cbz[0] = bz0;
   assign cez[0] = ez0; assign cfl[0] = flag0;
   // elbow vector waits beside the first half
   assign hex[0] = ex_ff; assign hey[0] = ey_ff;
   for (genvar g = 0; g < NS; g++) begin : g_dly
      always_ff @(posedge clock) begin
         if (adv) begin
            hex[g+1] <= hex[g];
            hey[g+1] <= hey[g];
         end
      end
   end
   for (genvar g = 0; g < NS; g++) begin : g_cor_a
      tlik_cordic_cell #(.Step(g)) u_cell (
         .clock, .en(adv),
         .ax_in(cax[g]), .ay_in(cay[g]), .bx_in(cbx[g]), .by_in(cby[g]),
         .az_in(caz[g]), .bz_in(cbz[g]), .ez_in(cez[g]), .flag_in(cfl[g]),
         .ax_out(cax[g+1]), .ay_out(cay[g+1]), .bx_out(cbx[g+1]), .by_out(cby[g+1]),
         .az_out(caz[g+1]), .bz_out(cbz[g+1]), .ez_out(cez[g+1]), .flag_out(cfl[g+1])
      );
   end
   // between halves: shoulder difference goes into ez slot, elbow into lane a
   logic signed [35:0] shz_ff;
   logic signed [63:0] mx, my;
   logic signed [35:0] mz;
   logic mfl;
   logic zt_d [NS+1], zk_d [NS+1], ze_d [NS+1];
   assign zt_d[0] = zero_t_ff; assign zk_d[0] = zero_k_ff; assign ze_d[0] = zero_e_ff;
   for (genvar g = 0; g < NS; g++) begin : g_zd
      always_ff @(posedge clock) begin
         if (adv) begin
            zt_d[g+1] <= zt_d[g]; zk_d[g+1] <= zk_d[g]; ze_d[g+1] <= ze_d[g];
         end
      end
   end
   logic ze_mid_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         shz_ff <= (zt_d[NS] ? 36'sd0 : caz[NS]) - (zk_d[NS] ? 36'sd0 : cbz[NS]);
         mx <= hex[NS]; my <= hey[NS]; mz <= cez[NS]; mfl <= cfl[NS];
         ze_mid_ff <= ze_d[NS];
      end
   end
   // second half uses lane a for the elbow, lane b idles
   logic signed [63:0] eax [NS+1], eay [NS+1], ebx [NS+1], eby [NS+1];
   logic signed [35:0] eaz [NS+1], ebz [NS+1], esz [NS+1];
   logic efl [NS+1];
   logic ezz [NS+1];
   assign eax[0] = mx; assign eay[0] = my; assign eaz[0] = mz;
   assign ebx[0] = '0; assign eby[0] = '0; assign ebz[0] = '0;
   assign esz[0] = shz_ff; assign efl[0] = mfl; assign ezz[0] = ze_mid_ff;
   for (genvar g = 0; g < NS; g++) begin : g_cor_b
      tlik_cordic_cell #(.Step(g)) u_cell (
         .clock, .en(adv),
         .ax_in(eax[g]), .ay_in(eay[g]), .bx_in(ebx[g]), .by_in(eby[g]),
         .az_in(eaz[g]), .bz_in(ebz[g]), .ez_in(esz[g]), .flag_in(efl[g]),
         .ax_out(eax[g+1]), .ay_out(eay[g+1]), .bx_out(ebx[g+1]), .by_out(eby[g+1]),
         .az_out(eaz[g+1]), .bz_out(ebz[g+1]), .ez_out(esz[g+1]), .flag_out(efl[g+1])
      );
      always_ff @(posedge clock) begin
         if (adv) ezz[g+1] <= ezz[g];
      end
   end

   // output: round half up to 1/256 degree and clamp
   logic signed [35:0] er, sr2;
   assign er = ((ezz[NS] ? 36'sd0 : eaz[NS]) + 36'sd128) >>> 8;
   assign sr2 = (esz[NS] + 36'sd128) >>> 8;
   logic [ElbowW-1:0] elbow_ff;
   logic signed [ShoulderW-1:0] shoulder_ff;
   logic flag_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         if (er < 0) elbow_ff <= '0;
         else if (er > ElbowMax) elbow_ff <= ElbowW'(ElbowMax);
         else elbow_ff <= er[ElbowW-1:0];
         if (sr2 < ShoulderMin) shoulder_ff <= ShoulderW'(ShoulderMin);
         else if (sr2 > ShoulderMax) shoulder_ff <= ShoulderW'(ShoulderMax);
         else shoulder_ff <= sr2[ShoulderW-1:0];
         flag_ff <= efl[NS];
      end
   end
   assign rsp.valid = vld_ff[Depth-1];
   assign rsp.elbow_degrees = elbow_ff;
   assign rsp.shoulder_degrees = shoulder_ff;
   assign rsp.out_of_reach = flag_ff;
endmodule
`default_nettype wire

// File: sv/tlik_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module tlik_checker import tlik_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [ElbowW-1:0] elbow
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready) else $error("req taken in stall");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> elbow <= ElbowMax) else $error("elbow range");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("valid after reset");
endmodule

bind two_link_planar_inverse_kinematics_core tlik_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .elbow(rsp.elbow_degrees)
);
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
   import tlik_pkg::*;

   // expected angles of one target
   typedef struct {
      logic [ElbowW-1:0] elbow;
      logic signed [ShoulderW-1:0] shoulder;
      logic reach_flag;
   } ik_angles_type;

   // floor shift for signed values
   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // vectoring atan2 in 1/65536 degree
   function automatic longint vector_angle(longint x, longint y);
      longint z, t, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = Deg90Q16;
         end else begin
            t = x; x = -y; y = t; z = -Deg90Q16;
         end
      end
      for (int i = 0; i < CordicStepsDefault && i < TableLen; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (y > 0) begin
            x += dx; y -= dy; z += longint'(atan_q16(i));
         end else begin
            x -= dx; y += dy; z -= longint'(atan_q16(i));
         end
      end
      return z;
   endfunction

   function automatic longint round_angle(longint z, longint lo, longint hi);
      longint r;
      r = floor_shift(z + 128, 8);
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return r;
   endfunction

   class arm_scoreboard;
      logic [LW-1:0] upper_len = UpperReset;
      logic [LW-1:0] lower_len = LowerReset;
      ik_angles_type pending[$];
      int errors = 0;

      function void set_length(logic [CfgIdxW-1:0] idx, logic [LW-1:0] v);
         if (idx == RegUpper) upper_len = v;
         else if (idx == RegLower) lower_len = v;
      endfunction

      function void note_target(logic signed [XW-1:0] tx, logic signed [XW-1:0] ty);
         longint x, y, l1, l2, num, den, c2, s2, k1, k2, sh, q;
         longint unsigned mag, c;
         ik_angles_type a;
         x = tx; y = ty;
         l1 = (upper_len == 0) ? 1 : upper_len;
         l2 = (lower_len == 0) ? 1 : lower_len;
         num = x * x + y * y - l1 * l1 - l2 * l2;
         den = 2 * l1 * l2;
         a.reach_flag = 1'b0;
         if (num >= den) begin
            c2 = 64'sd1 <<< 28;
            a.reach_flag = num > den;
         end else if (num <= -den) begin
            c2 = -(64'sd1 <<< 28);
            a.reach_flag = num < -den;
         end else begin
            mag = (num < 0) ? -num : num;
            q = longint'((mag << 28) / longint'(den));
            c2 = (num < 0) ? -q : q;
         end
         c = (c2 < 0) ? -c2 : c2;
         s2 = int_sqrt((64'd1 << 56) - c * c);
         k2 = l2 * s2;
         k1 = l1 * (64'sd1 <<< 28) + l2 * c2;
         sh = vector_angle(x * (64'sd1 <<< 24), y * (64'sd1 <<< 24))
              - vector_angle(k1, k2);
         a.elbow = ElbowW'(round_angle(vector_angle(c2, s2), 0, ElbowMax));
         a.shoulder = ShoulderW'(round_angle(sh, ShoulderMin, ShoulderMax));
         pending.push_back(a);
      endfunction

      function void check_angles(ik_angles_type got);
         ik_angles_type e;
         if (pending.size() == 0) begin
            $display("%t unexpected rsp transfer: elbow %0d shoulder %0d flag %0d",
                     $time, got.elbow, got.shoulder, got.reach_flag);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.elbow !== e.elbow) begin
            $display("%t elbow_degrees expected %0d actual %0d", $time, e.elbow, got.elbow);
            errors++;
         end
         if (got.shoulder !== e.shoulder) begin
            $display("%t shoulder_degrees expected %0d actual %0d",
                     $time, e.shoulder, got.shoulder);
            errors++;
         end
         if (got.reach_flag !== e.reach_flag) begin
            $display("%t out_of_reach expected %0d actual %0d",
                     $time, e.reach_flag, got.reach_flag);
            errors++;
         end
      endfunction
   endclass

   localparam int Latency = 4 + DivSteps + 1 + SqrtSteps + 2 + 2 * CordicStepsDefault + 2;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [CfgIdxW-1:0] csr_index = '0;
   logic [LW-1:0] csr_write_data = '0;
   bit sending_done = 0;
   int rsp_wait = 0;
   arm_scoreboard board = new();

   tlik_req_if req ();
   tlik_rsp_if rsp ();

   initial begin
      req.valid = 0;
      req.target_x = '0;
      req.target_y = '0;
      rsp.ready = 0;
   end

   two_link_planar_inverse_kinematics_core u_dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data), .req(req.sink), .rsp(rsp.source)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // note a transfer on each side at the edge it happens
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) board.note_target(req.target_x, req.target_y);
      if (!reset && rsp.valid && rsp.ready)
         board.check_angles('{rsp.elbow_degrees, rsp.shoulder_degrees, rsp.out_of_reach});
   end

   // one register write while the chain is empty
   task automatic write_length(logic [CfgIdxW-1:0] idx, logic [LW-1:0] v);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 0;
      board.set_length(idx, v);
      @(posedge clock);
   endtask

   // drive one target, random gap before it when gaps is set, hold until the transfer
   task automatic send_target(logic signed [XW-1:0] x, logic signed [XW-1:0] y, bit gaps);
      int gap;
      gap = gaps ? int'($urandom_range(0, 11)) : 0;
      if (gap != 0) begin
         req.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1;
      req.target_x <= x;
      req.target_y <= y;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic drain();
      req.valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
   endtask

   // mostly points within +-60000 on each axis, the rest fully random
   task automatic random_target(bit gaps);
      int k;
      logic signed [XW-1:0] x, y;
      k = $urandom_range(0, 9);
      if (k < 2) begin
         x = XW'($urandom); y = XW'($urandom);
      end else begin
         x = XW'(int'($urandom_range(0, 2 * 60000)) - 60000);
         y = XW'(int'($urandom_range(0, 2 * 60000)) - 60000);
      end
      send_target(x, y, gaps);
   endtask

   // sink waits a random number of cycles after each result transfer until sending is done
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 0;
      end else if (sending_done) begin
         rsp.ready <= 1;
      end else begin
         if (rsp.valid && rsp.ready) rsp_wait = $urandom_range(0, 11);
         else if (rsp_wait != 0) rsp_wait--;
         rsp.ready <= (rsp_wait == 0);
      end
   end

   initial begin
      logic signed [XW-1:0] ex [6];
      ex = '{-18'sd131072, 18'sd131071, 18'sd0, -18'sd1, 18'sd1, 18'sd74240};
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: corners, origin, axes, exact reach limits
      foreach (ex[i]) foreach (ex[j]) if (j % 2 == 0 || i == j) send_target(ex[i], ex[j], 0);
      send_target(-18'sd5000, 18'sd0, 0);
      send_target(18'sd17920, 18'sd0, 0);
      drain();
      write_length(RegUpper, 16'd0);
      write_length(RegLower, 16'hFFFF);
      send_target(18'sd65535, 18'sd0, 0);
      send_target(18'sd65534, 18'sd0, 0);
      for (int n = 0; n < 150; n++) random_target(1);
      drain();
      write_length(RegUpper, 16'hFFFF);
      write_length(RegLower, 16'd1);
      for (int n = 0; n < 150; n++) random_target(1);
      drain();
      for (int p = 0; p < 10; p++) begin
         write_length(RegUpper, 16'($urandom_range(1000, 65535)));
         write_length(RegLower, 16'($urandom_range(1000, 65535)));
         for (int n = 0; n < 150; n++) random_target(p % 3 != 0);
         drain();
      end
      sending_done = 1;
      drain();
      if (board.errors == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

   initial begin
      #5ms;
      $display("tb: errors");
      $finish;
   end
endmodule
